// ----- rtl/io_channel_mode_controller_unit_assert.svh -----
// ----------------------------------------------------------------------------
// I/O channel mode controller: assertion macros
// Concurrent checks sampled on the rising clock, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef IO_CHANNEL_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define IO_CHANNEL_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/icmc_pkg.sv -----
// ----------------------------------------------------------------------------
// I/O channel mode controller package
// Command, mode, kind, direction and register codes plus the shared item types.
// ----------------------------------------------------------------------------
`default_nettype none

package icmc_pkg;

   // commands
   localparam logic [2:0] CMD_GET         = 3'd0;
   localparam logic [2:0] CMD_SET         = 3'd1;
   localparam logic [2:0] CMD_SET_PWM     = 3'd2;
   localparam logic [2:0] CMD_SET_MODE    = 3'd3;
   localparam logic [2:0] CMD_POLL        = 3'd4;
   localparam logic [2:0] CMD_TICK        = 3'd5;
   localparam logic [2:0] CMD_DISABLE_OUT = 3'd6;

   // channel modes
   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_AIN   = 3'd1;
   localparam logic [2:0] MODE_DIN   = 3'd2;
   localparam logic [2:0] MODE_DOUT  = 3'd3;
   localparam logic [2:0] MODE_SERVO = 3'd4;

   // hardware kinds
   localparam logic [1:0] KIND_ANALOG  = 2'd0;
   localparam logic [1:0] KIND_DIGITAL = 2'd1;
   localparam logic [1:0] KIND_MOSFET  = 2'd2;
   localparam logic [1:0] KIND_SERVO   = 2'd3;

   // pin directions
   localparam logic [1:0] DIR_INPUT  = 2'd0;
   localparam logic [1:0] DIR_PULLUP = 2'd1;
   localparam logic [1:0] DIR_OUTPUT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_CHANNEL_KIND  = 2'd0;
   localparam logic [1:0] CSR_PWM_CAPABLE   = 2'd1;
   localparam logic [1:0] CSR_HOLDOFF_TICKS = 2'd2;

   localparam logic [1:0]  KIND_RESET    = KIND_DIGITAL;
   localparam logic [15:0] HOLDOFF_RESET = 16'd100;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] value;
      logic               pin_low;
      logic [9:0]         adc_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel_kind;
      logic        pwm_capable;
      logic [15:0] holdoff_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/io_channel_mode_controller_unit.sv -----
// ----------------------------------------------------------------------------
// I/O channel mode controller
// One configurable I/O channel driven by a stream of commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries commands (get, set, set_pwm, set_mode, poll, tick,
//          disable_output) with their value and the sampled pin and ADC data.
//   rsp_*  returns one result per command: an optional reply (value report
//          or error) plus the current drive outputs and active mode.
//   csr_*  writes channel kind, PWM capability and report holdoff; always
//          ready, write only while no command is in flight.
//   The command sits in the request register and passes the decode logic
//   into the result register. Throughput is one command per cycle while
//   the receiver accepts results (rsp_ready high).
//   When the receiver stalls, the result holds and one more command can
//   still be taken into the request register; then req_ready drops.
//   Synchronous reset clears the channel to unconfigured input mode, empties
//   both stages and loads the register defaults (digital kind, no PWM,
//   holdoff 100).
// ----------------------------------------------------------------------------
`default_nettype none

module io_channel_mode_controller_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [15:0] req_value,
   input  wire logic               req_pin_low,
   input  wire logic [9:0]         req_adc_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_reply_valid,
   output logic                    rsp_reply_is_error,
   output logic signed [15:0]      rsp_reply_value,
   output logic [1:0]              rsp_pin_direction,
   output logic                    rsp_pin_level,
   output logic                    rsp_pwm_active,
   output logic signed [15:0]      rsp_pwm_duty,
   output logic                    rsp_servo_attached,
   output logic signed [15:0]      rsp_servo_position,
   output logic [2:0]              rsp_active_mode,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   icmc_pkg::cfg_type cfg_ff;
   icmc_pkg::cfg_type cfg_in;
   icmc_pkg::req_type item;
   logic              item_valid;
   logic              item_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            icmc_pkg::CSR_CHANNEL_KIND:  cfg_in.channel_kind  = csr_wdata[1:0];
            icmc_pkg::CSR_PWM_CAPABLE:   cfg_in.pwm_capable   = csr_wdata[0];
            icmc_pkg::CSR_HOLDOFF_TICKS: cfg_in.holdoff_ticks = csr_wdata;
            default: begin
               // no register here: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_kind  <= icmc_pkg::KIND_RESET;
         cfg_ff.pwm_capable   <= 1'b0;
         cfg_ff.holdoff_ticks <= icmc_pkg::HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   icmc_req_stage u_req_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_pin_low    (req_pin_low),
      .req_adc_sample (req_adc_sample),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   icmc_exec u_exec (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .item_valid         (item_valid),
      .item               (item),
      .item_take          (item_take),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_reply_is_error (rsp_reply_is_error),
      .rsp_reply_value    (rsp_reply_value),
      .rsp_pin_direction  (rsp_pin_direction),
      .rsp_pin_level      (rsp_pin_level),
      .rsp_pwm_active     (rsp_pwm_active),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_servo_attached (rsp_servo_attached),
      .rsp_servo_position (rsp_servo_position),
      .rsp_active_mode    (rsp_active_mode)
   );

endmodule

`default_nettype wire

// ----- rtl/icmc_req_stage.sv -----
// ----------------------------------------------------------------------------
// I/O channel mode controller: request register
// Captures one command per transfer and holds it until the execute stage
// takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module icmc_req_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [15:0] req_value,
   input  wire logic               req_pin_low,
   input  wire logic [9:0]         req_adc_sample,
   output logic                    item_valid,
   output icmc_pkg::req_type       item,
   input  wire logic               item_take
);

   logic              valid_ff;
   logic              valid_in;
   icmc_pkg::req_type item_ff;
   logic              load;

   assign req_ready = !valid_ff || item_take;
   assign load      = req_valid && req_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.command    <= req_command;
         item_ff.value      <= req_value;
         item_ff.pin_low    <= req_pin_low;
         item_ff.adc_sample <= req_adc_sample;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- rtl/icmc_exec.sv -----
// ----------------------------------------------------------------------------
// I/O channel mode controller: execute stage
// Decodes one command against the channel state, updates the state and
// loads the result register in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "io_channel_mode_controller_unit_assert.svh"

module icmc_exec (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire icmc_pkg::cfg_type  cfg,
   input  wire logic               item_valid,
   input  wire icmc_pkg::req_type  item,
   output logic                    item_take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_reply_valid,
   output logic                    rsp_reply_is_error,
   output logic signed [15:0]      rsp_reply_value,
   output logic [1:0]              rsp_pin_direction,
   output logic                    rsp_pin_level,
   output logic                    rsp_pwm_active,
   output logic signed [15:0]      rsp_pwm_duty,
   output logic                    rsp_servo_attached,
   output logic signed [15:0]      rsp_servo_position,
   output logic [2:0]              rsp_active_mode
);

   // channel state
   logic [2:0]  mode_ff,    mode_in;
   logic [15:0] held_ff,    held_in;
   logic        force_ff,   force_in;
   logic [15:0] holdoff_ff, holdoff_in;
   logic [1:0]  dir_ff,     dir_in;
   logic        level_ff,   level_in;
   logic        pwm_ff,     pwm_in;
   logic [15:0] duty_ff,    duty_in;
   logic        servo_ff,   servo_in;
   logic [15:0] pos_ff,     pos_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rep_valid_ff, rep_valid_in;
   logic        rep_err_ff,   rep_err_in;
   logic [15:0] rep_val_ff,   rep_val_in;

   logic        code_ok;
   logic [2:0]  code;
   logic [15:0] poll_sample;
   logic        set_level;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   assign code_ok     = (item.value[15:3] == 13'd0) && (item.value[2:0] <= icmc_pkg::MODE_SERVO);
   assign code        = item.value[2:0];
   assign poll_sample = (mode_ff == icmc_pkg::MODE_AIN) ? {6'd0, item.adc_sample}
                                                       : {15'd0, item.pin_low};
   assign set_level   = !item.value[15] && (item.value != 16'sd0);

   always_comb begin
      mode_in      = mode_ff;
      held_in      = held_ff;
      force_in     = force_ff;
      holdoff_in   = holdoff_ff;
      dir_in       = dir_ff;
      level_in     = level_ff;
      pwm_in       = pwm_ff;
      duty_in      = duty_ff;
      servo_in     = servo_ff;
      pos_in       = pos_ff;
      rep_valid_in = 1'b0;
      rep_err_in   = 1'b0;
      rep_val_in   = 16'd0;

      unique case (item.command)
         icmc_pkg::CMD_GET: begin
            rep_valid_in = 1'b1;
            if (mode_ff == icmc_pkg::MODE_AIN || mode_ff == icmc_pkg::MODE_DIN) begin
               rep_val_in = poll_sample;
            end else begin
               rep_val_in = held_ff;
            end
         end
         icmc_pkg::CMD_SET: begin
            rep_valid_in = 1'b1;
            if (mode_ff == icmc_pkg::MODE_SERVO) begin
               held_in    = item.value;
               pos_in     = item.value;
               rep_val_in = item.value;
            end else if (mode_ff == icmc_pkg::MODE_DOUT) begin
               held_in    = {15'd0, set_level};
               level_in   = set_level;
               pwm_in     = 1'b0;
               rep_val_in = {15'd0, set_level};
            end else begin
               rep_err_in = 1'b1;
            end
         end
         icmc_pkg::CMD_SET_PWM: begin
            rep_valid_in = 1'b1;
            if (!cfg.pwm_capable) begin
               rep_err_in = 1'b1;
            end else begin
               // switch to digital out first when needed
               if (mode_ff != icmc_pkg::MODE_DOUT) begin
                  force_in = 1'b1;
                  if (mode_ff == icmc_pkg::MODE_SERVO) begin
                     servo_in = 1'b0;
                  end
                  mode_in  = icmc_pkg::MODE_DOUT;
                  dir_in   = icmc_pkg::DIR_OUTPUT;
                  level_in = 1'b0;
               end
               held_in    = item.value;
               duty_in    = item.value;
               pwm_in     = 1'b1;
               rep_val_in = item.value;
            end
         end
         icmc_pkg::CMD_SET_MODE: begin
            force_in = 1'b1;
            if (!(code_ok && code == mode_ff)) begin
               if (mode_ff == icmc_pkg::MODE_SERVO) begin
                  servo_in = 1'b0;
               end
               held_in = 16'd0;
               if (code_ok) begin
                  unique case (code)
                     icmc_pkg::MODE_AIN: begin
                        if (cfg.channel_kind != icmc_pkg::KIND_ANALOG) begin
                           rep_valid_in = 1'b1;
                           rep_err_in   = 1'b1;
                        end else begin
                           mode_in = icmc_pkg::MODE_AIN;
                           dir_in  = icmc_pkg::DIR_INPUT;
                           pwm_in  = 1'b0;
                        end
                     end
                     icmc_pkg::MODE_DIN: begin
                        if (cfg.channel_kind == icmc_pkg::KIND_MOSFET) begin
                           rep_valid_in = 1'b1;
                           rep_err_in   = 1'b1;
                        end else begin
                           mode_in = icmc_pkg::MODE_DIN;
                           dir_in  = icmc_pkg::DIR_PULLUP;
                           pwm_in  = 1'b0;
                        end
                     end
                     icmc_pkg::MODE_DOUT: begin
                        mode_in  = icmc_pkg::MODE_DOUT;
                        dir_in   = icmc_pkg::DIR_OUTPUT;
                        level_in = 1'b0;
                        pwm_in   = 1'b0;
                     end
                     icmc_pkg::MODE_SERVO: begin
                        if (cfg.channel_kind != icmc_pkg::KIND_SERVO) begin
                           rep_valid_in = 1'b1;
                           rep_err_in   = 1'b1;
                        end else begin
                           mode_in  = icmc_pkg::MODE_SERVO;
                           dir_in   = icmc_pkg::DIR_OUTPUT;
                           pwm_in   = 1'b0;
                           servo_in = 1'b1;
                           pos_in   = 16'd0;
                        end
                     end
                     default: begin
                        // unconfigured code: detach and clear only
                     end
                  endcase
               end
            end
         end
         icmc_pkg::CMD_POLL: begin
            if ((mode_ff == icmc_pkg::MODE_AIN || mode_ff == icmc_pkg::MODE_DIN)
                && holdoff_ff == 16'd0) begin
               if (poll_sample != held_ff || force_ff) begin
                  held_in      = poll_sample;
                  rep_valid_in = 1'b1;
                  rep_val_in   = poll_sample;
                  holdoff_in   = cfg.holdoff_ticks;
               end
            end
            force_in = 1'b0;
         end
         icmc_pkg::CMD_TICK: begin
            if (holdoff_ff != 16'd0) begin
               holdoff_in = holdoff_ff - 16'd1;
            end
         end
         icmc_pkg::CMD_DISABLE_OUT: begin
            if (mode_ff == icmc_pkg::MODE_DOUT) begin
               held_in      = 16'd0;
               level_in     = 1'b0;
               pwm_in       = 1'b0;
               rep_valid_in = 1'b1;
            end
         end
         default: begin
            // unused command: drop
         end
      endcase
   end

   always_comb begin
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= icmc_pkg::MODE_NONE;
         held_ff      <= 16'd0;
         force_ff     <= 1'b0;
         holdoff_ff   <= 16'd0;
         dir_ff       <= icmc_pkg::DIR_INPUT;
         level_ff     <= 1'b0;
         pwm_ff       <= 1'b0;
         duty_ff      <= 16'd0;
         servo_ff     <= 1'b0;
         pos_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            mode_ff    <= mode_in;
            held_ff    <= held_in;
            force_ff   <= force_in;
            holdoff_ff <= holdoff_in;
            dir_ff     <= dir_in;
            level_ff   <= level_in;
            pwm_ff     <= pwm_in;
            duty_ff    <= duty_in;
            servo_ff   <= servo_in;
            pos_ff     <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rep_valid_ff <= rep_valid_in;
         rep_err_ff   <= rep_err_in;
         rep_val_ff   <= rep_val_in;
      end
   end

   // drive state only moves when a result is loaded, so it tracks the result
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_valid    = rep_valid_ff;
   assign rsp_reply_is_error = rep_err_ff;
   assign rsp_reply_value    = rep_val_ff;
   assign rsp_pin_direction  = dir_ff;
   assign rsp_pin_level      = level_ff;
   assign rsp_pwm_active     = pwm_ff;
   assign rsp_pwm_duty       = duty_ff;
   assign rsp_servo_attached = servo_ff;
   assign rsp_servo_position = pos_ff;
   assign rsp_active_mode    = mode_ff;

   `ICMC_ASSERT_SAME(a_pwm_only_dout, clock, reset, pwm_ff, mode_ff == icmc_pkg::MODE_DOUT, "pwm active outside digital out")
   `ICMC_ASSERT_SAME(a_servo_only_servo, clock, reset, servo_ff, mode_ff == icmc_pkg::MODE_SERVO, "servo attached outside servo mode")
   `ICMC_ASSERT_NEXT(a_set_mode_forces, clock, reset, item_take && item.command == icmc_pkg::CMD_SET_MODE, force_ff, "set_mode did not arm forced report")
   `ICMC_ASSERT_NEXT(a_tick_counts, clock, reset, item_take && item.command == icmc_pkg::CMD_TICK && holdoff_ff != 16'd0, holdoff_ff == $past(holdoff_ff) - 16'd1, "tick did not count holdoff down")
   `ICMC_ASSERT_SAME(a_error_reply_zero, clock, reset, rsp_valid_ff && rep_err_ff, rep_valid_ff && rep_val_ff == 16'd0, "error reply malformed")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// I/O channel mode controller testbench
// Sends directed and random command streams with random gaps on both sides,
// predicts every result with a cycle-free channel model held in the bench,
// and compares each returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned PRINT_LIMIT  = 100;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 140;
   localparam logic [2:0]  CMD_UNUSED   = 3'd7;

   typedef struct packed {
      logic        reply_valid;
      logic        reply_is_error;
      logic [15:0] reply_value;
      logic [1:0]  pin_direction;
      logic        pin_level;
      logic        pwm_active;
      logic [15:0] pwm_duty;
      logic        servo_attached;
      logic [15:0] servo_position;
      logic [2:0]  active_mode;
   } chan_result_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [2:0]         req_command    = icmc_pkg::CMD_GET;
   logic signed [15:0] req_value      = '0;
   logic               req_pin_low    = 1'b0;
   logic [9:0]         req_adc_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic               rsp_reply_valid;
   logic               rsp_reply_is_error;
   logic signed [15:0] rsp_reply_value;
   logic [1:0]         rsp_pin_direction;
   logic               rsp_pin_level;
   logic               rsp_pwm_active;
   logic signed [15:0] rsp_pwm_duty;
   logic               rsp_servo_attached;
   logic signed [15:0] rsp_servo_position;
   logic [2:0]         rsp_active_mode;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index      = icmc_pkg::CSR_CHANNEL_KIND;
   logic [15:0]        csr_wdata      = '0;

   // channel model: configuration and state
   logic [1:0]        cfg_kind;
   logic              cfg_pwm_cap;
   logic [15:0]       cfg_holdoff;
   logic [2:0]        ch_mode;
   logic [15:0]       ch_held;
   logic              ch_force;
   logic [15:0]       ch_holdoff_left;
   logic [1:0]        ch_dir;
   logic              ch_level;
   logic              ch_pwm_on;
   logic [15:0]       ch_duty;
   logic              ch_servo_on;
   logic [15:0]       ch_servo_pos;
   chan_result_type   pred;
   icmc_pkg::req_type seen_req;

   chan_result_type expected_results[$];
   int unsigned  error_count     = 0;
   int unsigned  items_accepted  = 0;
   int unsigned  results_checked = 0;
   int unsigned  value_replies   = 0;
   int unsigned  error_replies   = 0;
   int unsigned  stall_count     = 0;
   bit           no_idle         = 1'b0;

   io_channel_mode_controller_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_value          (req_value),
      .req_pin_low        (req_pin_low),
      .req_adc_sample     (req_adc_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_reply_is_error (rsp_reply_is_error),
      .rsp_reply_value    (rsp_reply_value),
      .rsp_pin_direction  (rsp_pin_direction),
      .rsp_pin_level      (rsp_pin_level),
      .rsp_pwm_active     (rsp_pwm_active),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_servo_attached (rsp_servo_attached),
      .rsp_servo_position (rsp_servo_position),
      .rsp_active_mode    (rsp_active_mode),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // channel model
   // ------------------------------------------------------------------------
   function automatic void post_reply(input logic err, input logic [15:0] v);
      pred.reply_valid    = 1'b1;
      pred.reply_is_error = err;
      pred.reply_value    = err ? 16'd0 : v;
   endfunction

   // known is low for codes outside 0..4; those still detach and clear
   function automatic void enter_mode(input logic known, input logic [2:0] code);
      ch_force = 1'b1;
      if (known && code == ch_mode) return;
      if (ch_mode == icmc_pkg::MODE_SERVO) ch_servo_on = 1'b0;
      ch_held = '0;
      if (known) begin
         case (code)
            icmc_pkg::MODE_AIN: begin
               if (cfg_kind != icmc_pkg::KIND_ANALOG) post_reply(1'b1, '0);
               else begin
                  ch_mode   = icmc_pkg::MODE_AIN;
                  ch_dir    = icmc_pkg::DIR_INPUT;
                  ch_pwm_on = 1'b0;
               end
            end
            icmc_pkg::MODE_DIN: begin
               if (cfg_kind == icmc_pkg::KIND_MOSFET) post_reply(1'b1, '0);
               else begin
                  ch_mode   = icmc_pkg::MODE_DIN;
                  ch_dir    = icmc_pkg::DIR_PULLUP;
                  ch_pwm_on = 1'b0;
               end
            end
            icmc_pkg::MODE_DOUT: begin
               ch_mode   = icmc_pkg::MODE_DOUT;
               ch_dir    = icmc_pkg::DIR_OUTPUT;
               ch_level  = 1'b0;
               ch_pwm_on = 1'b0;
            end
            icmc_pkg::MODE_SERVO: begin
               if (cfg_kind != icmc_pkg::KIND_SERVO) post_reply(1'b1, '0);
               else begin
                  ch_mode      = icmc_pkg::MODE_SERVO;
                  ch_dir       = icmc_pkg::DIR_OUTPUT;
                  ch_pwm_on    = 1'b0;
                  ch_servo_on  = 1'b1;
                  ch_servo_pos = '0;
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void write_output(input logic [15:0] v);
      logic lvl;
      lvl = !v[15] && (v != 16'd0);
      if (ch_mode == icmc_pkg::MODE_SERVO) begin
         ch_held      = v;
         ch_servo_pos = v;
         post_reply(1'b0, v);
      end else if (ch_mode == icmc_pkg::MODE_DOUT) begin
         ch_held   = {15'd0, lvl};
         ch_level  = lvl;
         ch_pwm_on = 1'b0;
         post_reply(1'b0, {15'd0, lvl});
      end else begin
         post_reply(1'b1, '0);
      end
   endfunction

   function automatic chan_result_type predict_channel(input icmc_pkg::req_type rq);
      logic [15:0] sampled;
      pred = '0;
      case (rq.command)
         icmc_pkg::CMD_GET: begin
            if (ch_mode == icmc_pkg::MODE_AIN) post_reply(1'b0, {6'd0, rq.adc_sample});
            else if (ch_mode == icmc_pkg::MODE_DIN) post_reply(1'b0, {15'd0, rq.pin_low});
            else post_reply(1'b0, ch_held);
         end
         icmc_pkg::CMD_SET: write_output(rq.value);
         icmc_pkg::CMD_SET_PWM: begin
            if (!cfg_pwm_cap) post_reply(1'b1, '0);
            else begin
               if (ch_mode != icmc_pkg::MODE_DOUT) enter_mode(1'b1, icmc_pkg::MODE_DOUT);
               ch_held   = rq.value;
               ch_duty   = rq.value;
               ch_pwm_on = 1'b1;
               post_reply(1'b0, rq.value);
            end
         end
         icmc_pkg::CMD_SET_MODE: begin
            enter_mode(rq.value[15:3] == 13'd0 && rq.value[2:0] <= icmc_pkg::MODE_SERVO,
                       rq.value[2:0]);
         end
         icmc_pkg::CMD_POLL: begin
            if ((ch_mode == icmc_pkg::MODE_AIN || ch_mode == icmc_pkg::MODE_DIN)
                && ch_holdoff_left == 16'd0) begin
               sampled = (ch_mode == icmc_pkg::MODE_AIN) ? {6'd0, rq.adc_sample}
                                                         : {15'd0, rq.pin_low};
               if (sampled != ch_held || ch_force) begin
                  ch_held         = sampled;
                  ch_holdoff_left = cfg_holdoff;
                  post_reply(1'b0, sampled);
               end
            end
            ch_force = 1'b0;
         end
         icmc_pkg::CMD_TICK: begin
            if (ch_holdoff_left != 16'd0) ch_holdoff_left = ch_holdoff_left - 16'd1;
         end
         icmc_pkg::CMD_DISABLE_OUT: begin
            if (ch_mode == icmc_pkg::MODE_DOUT) write_output('0);
         end
         default: ;
      endcase
      pred.pin_direction  = ch_dir;
      pred.pin_level      = ch_level;
      pred.pwm_active     = ch_pwm_on;
      pred.pwm_duty       = ch_duty;
      pred.servo_attached = ch_servo_on;
      pred.servo_position = ch_servo_pos;
      pred.active_mode    = ch_mode;
      return pred;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_checked, name, got, want));
      end
   endtask

   task automatic check_result();
      chan_result_type want;
      if (expected_results.size() == 0) begin
         report_error("result transfer with no command outstanding");
         return;
      end
      want = expected_results.pop_front();
      check_field("reply_valid", 16'(rsp_reply_valid), 16'(want.reply_valid));
      check_field("reply_is_error", 16'(rsp_reply_is_error), 16'(want.reply_is_error));
      check_field("reply_value", rsp_reply_value, want.reply_value);
      check_field("pin_direction", 16'(rsp_pin_direction), 16'(want.pin_direction));
      check_field("pin_level", 16'(rsp_pin_level), 16'(want.pin_level));
      check_field("pwm_active", 16'(rsp_pwm_active), 16'(want.pwm_active));
      check_field("pwm_duty", rsp_pwm_duty, want.pwm_duty);
      check_field("servo_attached", 16'(rsp_servo_attached), 16'(want.servo_attached));
      check_field("servo_position", rsp_servo_position, want.servo_position);
      check_field("active_mode", 16'(rsp_active_mode), 16'(want.active_mode));
      if (want.reply_valid && want.reply_is_error) error_replies++;
      else if (want.reply_valid) value_replies++;
      results_checked++;
   endtask

   // track config writes and commands at transfer, then check results
   always @(posedge clock) begin
      if (reset) begin
         cfg_kind        = icmc_pkg::KIND_RESET;
         cfg_pwm_cap     = 1'b0;
         cfg_holdoff     = icmc_pkg::HOLDOFF_RESET;
         ch_mode         = icmc_pkg::MODE_NONE;
         ch_held         = '0;
         ch_force        = 1'b0;
         ch_holdoff_left = '0;
         ch_dir          = icmc_pkg::DIR_INPUT;
         ch_level        = 1'b0;
         ch_pwm_on       = 1'b0;
         ch_duty         = '0;
         ch_servo_on     = 1'b0;
         ch_servo_pos    = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               icmc_pkg::CSR_CHANNEL_KIND:  cfg_kind    = csr_wdata[1:0];
               icmc_pkg::CSR_PWM_CAPABLE:   cfg_pwm_cap = csr_wdata[0];
               icmc_pkg::CSR_HOLDOFF_TICKS: cfg_holdoff = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            seen_req = {req_command, req_value, req_pin_low, req_adc_sample};
            expected_results.push_back(predict_channel(seen_req));
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) check_result();
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 11);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      wait (stall_count >= STALL_LIMIT);
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] val,
                           input logic pin_low, input logic [9:0] adc);
      while (!no_idle && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_value      <= val;
      req_pin_low    <= pin_low;
      req_adc_sample <= adc;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   // drop valid and hold until every result is back and the pipe is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure_channel(input logic [1:0] kind, input logic pwm_cap,
                                    input logic [15:0] holdoff);
      logic [1:0]  idx [3];
      logic [15:0] dat [3];
      int          i;
      idx = '{icmc_pkg::CSR_CHANNEL_KIND, icmc_pkg::CSR_PWM_CAPABLE,
              icmc_pkg::CSR_HOLDOFF_TICKS};
      dat = '{{14'd0, kind}, {15'd0, pwm_cap}, holdoff};
      wait_drained();
      for (i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= dat[i];
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_unconfigured();
      send_cmd(icmc_pkg::CMD_GET, 16'd0, 1'b1, 10'd1023);
      send_cmd(icmc_pkg::CMD_SET, 16'd5, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET_PWM, 16'd100, 1'b0, 10'd0);
      send_cmd(CMD_UNUSED, 16'hFFFF, 1'b1, 10'd1023);
   endtask

   task automatic test_digital_modes();
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_AIN}, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_DOUT}, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET, 16'h7FFF, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_DISABLE_OUT, 16'h7FFF, 1'b0, 10'd0);
      // negative code: no mode change, held value still clears
      send_cmd(icmc_pkg::CMD_SET_MODE, 16'h8000, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_DOUT}, 1'b0, 10'd0);
   endtask

   task automatic test_input_reports();
      configure_channel(icmc_pkg::KIND_DIGITAL, 1'b0, 16'd0);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_DIN}, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b1, 10'd0);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b1, 10'd0);
      configure_channel(icmc_pkg::KIND_DIGITAL, 1'b0, 16'd2);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b1, 10'd0);
      send_cmd(icmc_pkg::CMD_TICK, 16'd0, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_TICK, 16'd0, 1'b0, 10'd0);
   endtask

   task automatic test_pwm_and_servo();
      configure_channel(icmc_pkg::KIND_SERVO, 1'b1, 16'd0);
      send_cmd(icmc_pkg::CMD_SET_PWM, 16'h8000, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_SERVO}, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET, 16'hFFFF, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET_PWM, 16'h7FFF, 1'b0, 10'd0);
   endtask

   task automatic test_analog_and_mosfet();
      configure_channel(icmc_pkg::KIND_ANALOG, 1'b0, 16'd0);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_AIN}, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b0, 10'd1023);
      send_cmd(icmc_pkg::CMD_GET, 16'd0, 1'b1, 10'd0);
      configure_channel(icmc_pkg::KIND_MOSFET, 1'b0, icmc_pkg::HOLDOFF_RESET);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_DIN}, 1'b0, 10'd0);
   endtask

   task automatic test_random_traffic();
      logic [15:0] extremes [5];
      logic [2:0]  cmd;
      logic [15:0] val;
      logic        pin;
      logic [9:0]  adc;
      int unsigned r;
      int unsigned phase;
      int unsigned n;
      extremes = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
      pin = 1'b0;
      adc = '0;
      for (phase = 0; phase < PHASES; phase++) begin
         configure_channel(phase[1:0], phase[2],
                           (phase == 0) ? 16'd0 : 16'($urandom_range(0, 12)));
         no_idle = (phase == 5);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8) cmd = icmc_pkg::CMD_GET;
            else if (r < 20) cmd = icmc_pkg::CMD_SET;
            else if (r < 30) cmd = icmc_pkg::CMD_SET_PWM;
            else if (r < 48) cmd = icmc_pkg::CMD_SET_MODE;
            else if (r < 70) cmd = icmc_pkg::CMD_POLL;
            else if (r < 92) cmd = icmc_pkg::CMD_TICK;
            else if (r < 98) cmd = icmc_pkg::CMD_DISABLE_OUT;
            else cmd = CMD_UNUSED;
            if (cmd == icmc_pkg::CMD_SET_MODE) begin
               r = $urandom_range(0, 9);
               if (r < 8) val = 16'($urandom_range(0, 4));
               else if (r == 8) val = 16'($urandom_range(5, 32767));
               else val = 16'($urandom_range(32768, 65535));
            end else if ($urandom_range(0, 3) == 0) begin
               val = extremes[$urandom_range(0, 4)];
            end else begin
               val = 16'($urandom_range(0, 65535));
            end
            // hold the samples for stretches so unchanged polls occur
            if ($urandom_range(0, 99) < 30) adc = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 99) < 25) pin = 1'($urandom_range(0, 1));
            send_cmd(cmd, val, pin, adc);
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_max_holdoff();
      configure_channel(icmc_pkg::KIND_ANALOG, 1'b1, 16'hFFFF);
      // run down any counter left from the random phases
      repeat (16) send_cmd(icmc_pkg::CMD_TICK, 16'd0, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_SET_MODE, {13'd0, icmc_pkg::MODE_AIN}, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b0, 10'd1023);
      send_cmd(icmc_pkg::CMD_TICK, 16'd0, 1'b0, 10'd0);
      send_cmd(icmc_pkg::CMD_POLL, 16'd0, 1'b1, 10'd0);
      send_cmd(icmc_pkg::CMD_GET, 16'd0, 1'b1, 10'd0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unconfigured();
      test_digital_modes();
      test_input_reports();
      test_pwm_and_servo();
      test_analog_and_mosfet();
      test_random_traffic();
      test_max_holdoff();
      wait_drained();
      $display("Run covered %0d commands over all channel kinds, PWM on and off,",
               items_accepted);
      $display("holdoff 0 to 65535: %0d results checked, %0d value and %0d error replies",
               results_checked, value_replies, error_replies);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/icmc_pkg.sv
rtl/icmc_req_stage.sv
rtl/icmc_exec.sv
rtl/io_channel_mode_controller_unit.sv
bench/tb_top.sv
